// ===== design/btb_two_level_branch_predictor_assert.svh =====
// Assertion macros for the branch predictor
`ifndef BTB_TWO_LEVEL_BRANCH_PREDICTOR_ASSERT_SVH
`define BTB_TWO_LEVEL_BRANCH_PREDICTOR_ASSERT_SVH

// same-cycle implication, off while in reset
`define BTB_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while in reset
`define BTB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/btb_pkg.sv =====
// Shared types and constants for the branch predictor
package btb_pkg;

    localparam logic [2:0] REG_INDEX_BITS   = 3'd0;
    localparam logic [2:0] REG_HISTORY_BITS = 3'd1;
    localparam logic [2:0] REG_TAG_BITS     = 3'd2;
    localparam logic [2:0] REG_COUNTER_INIT = 3'd3;
    localparam logic [2:0] REG_GLOBAL_HIST  = 3'd4;
    localparam logic [2:0] REG_GLOBAL_TABLE = 3'd5;
    localparam logic [2:0] REG_SHARE_MODE   = 3'd6;

    localparam logic       OP_PREDICT = 1'b0;
    localparam logic       OP_UPDATE  = 1'b1;

    localparam logic [1:0] SHARE_HIST = 2'd0;
    localparam logic [1:0] SHARE_LSB  = 2'd1;
    localparam logic [1:0] SHARE_MID  = 2'd2;

    localparam logic [1:0] CNT_RESET   = 2'd1;
    localparam logic [1:0] CNT_MAX     = 2'd3;
    localparam logic [1:0] CNT_TAKEN   = 2'd2;
    localparam logic [31:0] PC_STEP    = 32'd4;
    localparam int          MID_LSB    = 16;
    localparam int          LSB_LSB    = 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ENTRY,
        ST_LOOK,
        ST_ROWCLR,
        ST_CWAIT,
        ST_CDATA
    } btb_state_t;

    typedef struct packed {
        logic load_in;
        logic init_sweep;
        logic look;
        logic row_sweep;
        logic commit;
    } btb_cmd_t;

    typedef struct packed {
        logic is_update;
        logic miss;
        logic tbl_global;
        logic init_last;
        logic row_last;
        logic out_free;
    } btb_status_t;

endpackage

// ===== design/btb_ram.sv =====
// Generic simple dual-port RAM with registered read
module btb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/btb_ctrl.sv =====
// Sequencer for the branch predictor: clear, lookup, row reset, commit
module btb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  btb_pkg::btb_status_t status,
    output btb_pkg::btb_cmd_t    cmd
);
    import btb_pkg::*;

    btb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.init_sweep = 1'b1;
                if (status.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_ENTRY;
                end
            end
            ST_ENTRY: begin
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                cmd.look = 1'b1;
                if (status.is_update && status.miss && !status.tbl_global) begin
                    state_next = ST_ROWCLR;
                end else begin
                    state_next = ST_CWAIT;
                end
            end
            ST_ROWCLR: begin
                cmd.row_sweep = 1'b1;
                if (status.row_last) begin
                    state_next = ST_CWAIT;
                end
            end
            ST_CWAIT: begin
                state_next = ST_CDATA;
            end
            ST_CDATA: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end
endmodule

// ===== design/btb_dp.sv =====
// Datapath: config registers, BTB and counter memories, counts, result register
module btb_dp #(
    parameter int MAX_ENTRIES = 32,
    parameter int MAX_HISTORY = 8,
    parameter int TAG_WIDTH   = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  btb_pkg::btb_cmd_t    cmd,
    output btb_pkg::btb_status_t status,
    input  logic                 s_tuser,
    input  logic [103:0]         s_tdata,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [4:0]           cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [103:0]         m_tdata
);
    import btb_pkg::*;

    localparam int IDX_W    = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int EA_W     = (IDX_W > 0) ? IDX_W : 1;
    localparam int HW       = MAX_HISTORY;
    localparam int LC_W     = EA_W + HW;
    localparam int ENT_W    = 1 + TAG_WIDTH + 32 + HW;

    // configuration
    logic [2:0] ib_cfg_reg;
    logic [3:0] hist_cfg_reg;
    logic [4:0] tag_cfg_reg;
    logic [1:0] cinit_reg;
    logic       ghist_reg;
    logic       gtbl_reg;
    logic [1:0] share_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ib_cfg_reg   <= 3'd5;
            hist_cfg_reg <= 4'd8;
            tag_cfg_reg  <= 5'd16;
            cinit_reg    <= 2'd1;
            ghist_reg    <= 1'b0;
            gtbl_reg     <= 1'b0;
            share_reg    <= 2'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_INDEX_BITS:   ib_cfg_reg   <= cfg_data[2:0];
                REG_HISTORY_BITS: hist_cfg_reg <= cfg_data[3:0];
                REG_TAG_BITS:     tag_cfg_reg  <= cfg_data;
                REG_COUNTER_INIT: cinit_reg    <= cfg_data[1:0];
                REG_GLOBAL_HIST:  ghist_reg    <= cfg_data[0];
                REG_GLOBAL_TABLE: gtbl_reg     <= cfg_data[0];
                REG_SHARE_MODE:   share_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // input beat
    logic        op_reg;
    logic [31:0] pc_reg;
    logic [31:0] tgt_reg;
    logic        tk_reg;
    logic [31:0] pdst_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= s_tuser;
            pc_reg   <= s_tdata[31:0];
            tgt_reg  <= s_tdata[63:32];
            tk_reg   <= s_tdata[64];
            pdst_reg <= s_tdata[96:65];
        end
    end

    // effective widths and masks
    logic [3:0]           ib;
    logic [3:0]           hb;
    logic [4:0]           tb;
    logic [EA_W-1:0]      e_cur;
    logic [31:0]          pc_sh;
    logic [TAG_WIDTH-1:0] tag_cur;
    logic [HW-1:0]        hmask;

    always_comb begin
        ib = (4'(ib_cfg_reg) < 4'(IDX_W)) ? 4'(ib_cfg_reg) : 4'(IDX_W);
        if (hist_cfg_reg == 4'd0) begin
            hb = 4'd1;
        end else if (hist_cfg_reg > 4'(HW)) begin
            hb = 4'(HW);
        end else begin
            hb = hist_cfg_reg;
        end
        tb      = (tag_cfg_reg > 5'(TAG_WIDTH)) ? 5'(TAG_WIDTH) : tag_cfg_reg;
        e_cur   = pc_reg[2 +: EA_W] & ~({EA_W{1'b1}} << ib);
        pc_sh   = pc_reg >> (6'd2 + 6'(ib));
        tag_cur = pc_sh[TAG_WIDTH-1:0] & ~({TAG_WIDTH{1'b1}} << tb);
        hmask   = ~({HW{1'b1}} << hb);
    end

    // sweep counter for the power-up clear and for row resets
    logic [LC_W-1:0] sweep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.look) begin
            sweep_reg <= '0;
        end else if (cmd.init_sweep || cmd.row_sweep) begin
            sweep_reg <= sweep_reg + LC_W'(1);
        end
    end

    // entry memory: {valid, tag, target, local history}
    logic [ENT_W-1:0]     ent_rdata;
    logic [ENT_W-1:0]     ent_wdata;
    logic [EA_W-1:0]      ent_waddr;
    logic                 ent_we;
    logic                 ent_valid;
    logic [TAG_WIDTH-1:0] ent_tag;
    logic [31:0]          ent_tgt;
    logic [HW-1:0]        ent_hist;
    logic                 hit;
    logic [HW-1:0]        hist_sel;
    logic [HW-1:0]        shist_reg;

    assign ent_valid = ent_rdata[ENT_W-1];
    assign ent_tag   = ent_rdata[ENT_W-2 -: TAG_WIDTH];
    assign ent_tgt   = ent_rdata[HW +: 32];
    assign ent_hist  = ent_rdata[HW-1:0];
    assign hit       = ent_valid && (ent_tag == tag_cur);
    assign hist_sel  = (ghist_reg ? shist_reg : ent_hist) & hmask;

    // lookup results
    logic          hit_reg;
    logic [31:0]   tgt_st_reg;
    logic [HW-1:0] lhist_reg;
    logic [HW-1:0] hist_reg;

    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            hit_reg    <= hit;
            tgt_st_reg <= ent_tgt;
            lhist_reg  <= ent_hist;
            // replacement with per-entry history starts from a clean history
            hist_reg   <= (op_reg && !hit && !ghist_reg) ? '0 : hist_sel;
        end
    end

    // counter addressing
    logic [HW-1:0]   pc_bits;
    logic [HW-1:0]   sidx;
    logic [LC_W-1:0] laddr;
    logic [1:0]      lc_rdata;
    logic [1:0]      sh_rdata;
    logic [1:0]      cnt;
    logic [1:0]      cnt_bumped;
    logic [HW-1:0]   nh;
    logic [31:0]     pc4;

    always_comb begin
        case (share_reg)
            SHARE_LSB: pc_bits = pc_reg[LSB_LSB +: HW];
            SHARE_MID: pc_bits = pc_reg[MID_LSB +: HW];
            default:   pc_bits = '0;
        endcase
        sidx  = (hist_reg ^ pc_bits) & hmask;
        laddr = {e_cur, hist_reg};
        cnt   = gtbl_reg ? sh_rdata : lc_rdata;
        if (tk_reg) begin
            cnt_bumped = (cnt == CNT_MAX) ? CNT_MAX : cnt + 2'd1;
        end else begin
            cnt_bumped = (cnt == 2'd0) ? 2'd0 : cnt - 2'd1;
        end
        nh  = ((hist_reg << 1) | HW'(tk_reg)) & hmask;
        pc4 = pc_reg + PC_STEP;
    end

    logic upd_commit;
    assign upd_commit = cmd.commit && (op_reg == OP_UPDATE);

    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = e_cur;
        ent_wdata = {1'b1, tag_cur, tgt_reg, ghist_reg ? lhist_reg : nh};
        if (cmd.init_sweep) begin
            ent_we    = (sweep_reg[LC_W-1:EA_W] == '0);
            ent_waddr = sweep_reg[EA_W-1:0];
            ent_wdata = '0;
        end else if (upd_commit) begin
            ent_we = 1'b1;
        end
    end

    btb_ram #(.WIDTH(ENT_W), .DEPTH(1 << EA_W)) u_ent_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (e_cur),
        .rdata (ent_rdata)
    );

    // per-entry counter rows
    logic            lc_we;
    logic [LC_W-1:0] lc_waddr;
    logic [1:0]      lc_wdata;

    always_comb begin
        lc_we    = 1'b0;
        lc_waddr = laddr;
        lc_wdata = cnt_bumped;
        if (cmd.init_sweep) begin
            lc_we    = 1'b1;
            lc_waddr = sweep_reg;
            lc_wdata = CNT_RESET;
        end else if (cmd.row_sweep) begin
            lc_we    = 1'b1;
            lc_waddr = {e_cur, sweep_reg[HW-1:0]};
            lc_wdata = cinit_reg;
        end else if (upd_commit && !gtbl_reg) begin
            lc_we = 1'b1;
        end
    end

    btb_ram #(.WIDTH(2), .DEPTH(1 << LC_W)) u_lc_ram (
        .aclk  (aclk),
        .we    (lc_we),
        .waddr (lc_waddr),
        .wdata (lc_wdata),
        .raddr (laddr),
        .rdata (lc_rdata)
    );

    // shared counter table
    logic          sh_we;
    logic [HW-1:0] sh_waddr;
    logic [1:0]    sh_wdata;

    always_comb begin
        sh_we    = 1'b0;
        sh_waddr = sidx;
        sh_wdata = cnt_bumped;
        if (cmd.init_sweep) begin
            sh_we    = (sweep_reg[LC_W-1:HW] == '0);
            sh_waddr = sweep_reg[HW-1:0];
            sh_wdata = CNT_RESET;
        end else if (upd_commit && gtbl_reg) begin
            sh_we = 1'b1;
        end
    end

    btb_ram #(.WIDTH(2), .DEPTH(1 << HW)) u_sh_ram (
        .aclk  (aclk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .raddr (sidx),
        .rdata (sh_rdata)
    );

    // counts, shared history, result register
    logic [31:0] branch_reg, branch_next;
    logic [31:0] flush_reg, flush_next;
    logic        m_valid_reg;
    logic        m_taken_reg;
    logic [31:0] m_target_reg;
    logic        p_taken;

    always_comb begin
        branch_next = branch_reg;
        flush_next  = flush_reg;
        if (op_reg == OP_UPDATE) begin
            branch_next = branch_reg + 32'd1;
            if ((tk_reg ? tgt_reg : pc4) != pdst_reg) begin
                flush_next = flush_reg + 32'd1;
            end
        end
        p_taken = hit_reg && (cnt >= CNT_TAKEN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            branch_reg  <= '0;
            flush_reg   <= '0;
            shist_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                branch_reg  <= branch_next;
                flush_reg   <= flush_next;
                m_valid_reg <= 1'b1;
                if (upd_commit && ghist_reg) begin
                    shist_reg <= nh;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (op_reg == OP_UPDATE) begin
                m_taken_reg  <= 1'b0;
                m_target_reg <= '0;
            end else begin
                m_taken_reg  <= p_taken;
                m_target_reg <= p_taken ? tgt_st_reg : pc4;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, flush_reg, branch_reg, m_target_reg, m_taken_reg};

    assign status.is_update  = (op_reg == OP_UPDATE);
    assign status.miss       = !hit;
    assign status.tbl_global = gtbl_reg;
    assign status.init_last  = &sweep_reg;
    assign status.row_last   = &sweep_reg[HW-1:0];
    assign status.out_free   = !m_valid_reg || m_tready;
endmodule

// ===== design/btb_two_level_branch_predictor.sv =====
// Branch target buffer with two-level direction predictor, top level
//
// Input stream (s_*): one beat per predict or update; s_tuser is the operation.
// Result stream (m_*): exactly one result beat per input beat, in order.
// Config channel (cfg_*): always ready; write only while the block is idle.
// After an item is accepted it passes through entry read, lookup, counter
// read and commit; the next item can be accepted in the cycle after commit,
// so the block takes no new item before the current one has committed, as
// it steps through the entry memory and then the counter memory.
// An update that replaces an entry with per-entry counter tables first
// rewrites that entry's counter row with the configured initial value.
// After reset the block clears its memories, one address a cycle, and only
// then raises s_tready; config writes are taken meanwhile.
// A stalled receiver holds the result in the output register; a finished
// item waits in its commit step until that register frees up.
module btb_two_level_branch_predictor #(
    parameter int MAX_ENTRIES = 32,
    parameter int MAX_HISTORY = 8,
    parameter int TAG_WIDTH   = 30
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // pc, target_pc, taken, prev_dest, zero pad
    input  logic         s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // pred_taken, pred_target, branch_count,
                                    // flush_count, zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [4:0]   cfg_data
);
    import btb_pkg::*;

    btb_cmd_t    cmd;
    btb_status_t status;

    assign cfg_ready = 1'b1;

    btb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    btb_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_HISTORY (MAX_HISTORY),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

`include "btb_two_level_branch_predictor_assert.svh"

    `BTB_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `BTB_ASSERT_NOW(a_commit_has_slot, aclk, aresetn, cmd.commit, status.out_free)
    `BTB_ASSERT_NOW(a_row_clear_local, aclk, aresetn, cmd.row_sweep, !status.tbl_global)
    `BTB_ASSERT_NEXT(a_commit_shows, aclk, aresetn, cmd.commit, m_tvalid)
endmodule
